@@ hw/rtl/stkrm_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack remove-by-value package
// Shared widths, request and status codes, and the bundles that pass
// between the controller, the entry memory and the top level.
// ----------------------------------------------------------------------------
package stkrm_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int REQ_W       = 2;
  localparam int STAT_W      = 2;
  localparam int POS_W       = 4;
  localparam int OUT_CNT_W   = 5;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RANGE    = 2'd3
  } stat_t;

  typedef struct packed {
    stat_t                     status;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  top;
    logic signed [DATA_W-1:0]  rdval;
  } res_t;

  typedef struct packed {
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [DATA_W-1:0]         wr_data;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
  } mem_req_t;

endpackage

@@ hw/rtl/stkrm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module stkrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ hw/rtl/stkrm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stack controller
// Sequencer that runs push, read, and the search-and-shift of a remove
// against the entry memory, and holds the fill count and top value.
// ----------------------------------------------------------------------------
module stkrm_ctrl (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [stkrm_pkg::REQ_W-1:0]            in_req_type,
  input  logic signed [stkrm_pkg::DATA_W-1:0]    in_value,
  input  logic [stkrm_pkg::POS_W-1:0]            in_position,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output stkrm_pkg::res_t                        res,
  output stkrm_pkg::mem_req_t                    mem_req,
  input  logic [stkrm_pkg::DATA_W-1:0]           mem_rd_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_TOP_RD,
    S_TOP_WAIT,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t                                  state_r, state_nxt;
  logic [stkrm_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [stkrm_pkg::DATA_W-1:0]     top_r, top_nxt;
  logic [stkrm_pkg::DATA_W-1:0]            value_r, value_nxt;
  logic [stkrm_pkg::ADDR_W-1:0]            idx_r, idx_nxt;
  stkrm_pkg::stat_t                        status_r, status_nxt;
  logic signed [stkrm_pkg::DATA_W-1:0]     rdval_r, rdval_nxt;
  logic                                    accept;
  logic                                    pos_in_range;
  logic                                    shift_more;

  assign accept       = in_valid && (state_r == S_IDLE);
  assign in_stall     = (state_r != S_IDLE);
  assign pos_in_range = stkrm_pkg::CMP_W'(in_position) < stkrm_pkg::CMP_W'(cnt_r);
  assign shift_more   = (stkrm_pkg::CNT_W'(idx_r) + stkrm_pkg::CNT_W'(1)) < cnt_r;

  assign res_valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.count  = cnt_r;
  assign res.top    = top_r;
  assign res.rdval  = rdval_r;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    top_nxt          = top_r;
    value_nxt        = value_r;
    idx_nxt          = idx_r;
    status_nxt       = status_r;
    rdval_nxt        = rdval_r;
    mem_req.wr_en    = 1'b0;
    mem_req.wr_addr  = idx_r;
    mem_req.wr_data  = mem_rd_data;
    mem_req.rd_en    = 1'b0;
    mem_req.rd_addr  = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = stkrm_pkg::ST_OK;
          rdval_nxt  = '0;
          value_nxt  = in_value;
          state_nxt  = S_DONE;
          case (stkrm_pkg::req_t'(in_req_type))
            stkrm_pkg::REQ_PUSH: begin
              if (cnt_r == stkrm_pkg::CNT_W'(stkrm_pkg::STACK_DEPTH)) begin
                status_nxt = stkrm_pkg::ST_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = stkrm_pkg::ADDR_W'(cnt_r);
                mem_req.wr_data = in_value;
                cnt_nxt         = cnt_r + stkrm_pkg::CNT_W'(1);
                top_nxt         = in_value;
              end
            end
            stkrm_pkg::REQ_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = stkrm_pkg::ST_NOTFOUND;
              end else begin
                idx_nxt   = stkrm_pkg::ADDR_W'(cnt_r - stkrm_pkg::CNT_W'(1));
                state_nxt = S_SRCH_RD;
              end
            end
            stkrm_pkg::REQ_READ: begin
              if (pos_in_range) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = stkrm_pkg::ADDR_W'(in_position);
                state_nxt       = S_RD_WAIT;
              end else begin
                status_nxt = stkrm_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        mem_req.rd_en = 1'b1;
        state_nxt     = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (mem_rd_data == value_r) begin
          state_nxt = S_SH_RD;
        end else if (idx_r == '0) begin
          status_nxt = stkrm_pkg::ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = idx_r - stkrm_pkg::ADDR_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        if (shift_more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r + stkrm_pkg::ADDR_W'(1);
          state_nxt       = S_SH_WR;
        end else begin
          cnt_nxt   = cnt_r - stkrm_pkg::CNT_W'(1);
          state_nxt = S_TOP_RD;
        end
      end
      S_SH_WR: begin
        mem_req.wr_en = 1'b1;
        idx_nxt       = idx_r + stkrm_pkg::ADDR_W'(1);
        state_nxt     = S_SH_RD;
      end
      S_TOP_RD: begin
        if (cnt_r == '0) begin
          top_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = stkrm_pkg::ADDR_W'(cnt_r - stkrm_pkg::CNT_W'(1));
          state_nxt       = S_TOP_WAIT;
        end
      end
      S_TOP_WAIT: begin
        top_nxt   = mem_rd_data;
        state_nxt = S_DONE;
      end
      S_RD_WAIT: begin
        rdval_nxt = mem_rd_data;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      top_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      top_r   <= top_nxt;
    end
    value_r  <= value_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    rdval_r  <= rdval_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= stkrm_pkg::CNT_W'(stkrm_pkg::STACK_DEPTH))
    else $error("fill count above stack depth");

  a_wr_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (stkrm_pkg::CNT_W'(mem_req.wr_addr) <= cnt_r))
    else $error("memory write above the filled entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (status_r == stkrm_pkg::ST_FULL))
      |-> (cnt_r == stkrm_pkg::CNT_W'(stkrm_pkg::STACK_DEPTH)))
    else $error("full reported while stack has room");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("controller not busy after taking an item");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("read and write issued in one cycle");

endmodule

@@ hw/rtl/stack_remove_by_value_top.sv @@
// ----------------------------------------------------------------------------
// Stack with remove-by-value
// Bounded stack of signed 32-bit values with push, delete of the topmost
// matching entry, and indexed read; every item returns one result.
//
//   Channel  Handshake             Payload
//   in_      in_valid / in_stall   in_req_type, in_value, in_position
//   out_     out_valid / out_stall out_status, out_entry_count,
//                                  out_top_value, out_read_value
//
// A push goes from accept to the done state and the output register; a
// read also passes the read-wait state for the registered memory read.
// A remove reads and compares each entry from the top down to the match,
// moves each entry above the match one place down, then fetches the new
// top and hands over the result, never reading and writing at once.
// Reset clears the fill count and top value; entries need no clearing.
// One item is worked at a time; the next is taken while a result waits
// in the output register.
// ----------------------------------------------------------------------------
module stack_remove_by_value_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [stkrm_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [stkrm_pkg::DATA_W-1:0]  in_value,
  input  logic [stkrm_pkg::POS_W-1:0]          in_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stkrm_pkg::STAT_W-1:0]         out_status,
  output logic [stkrm_pkg::OUT_CNT_W-1:0]      out_entry_count,
  output logic signed [stkrm_pkg::DATA_W-1:0]  out_top_value,
  output logic signed [stkrm_pkg::DATA_W-1:0]  out_read_value
);

  stkrm_pkg::res_t                   res;
  stkrm_pkg::mem_req_t               mem_req;
  logic [stkrm_pkg::DATA_W-1:0]      mem_rd_data;
  logic                              res_valid;
  logic                              res_ready;
  logic                              out_valid_r;
  logic [stkrm_pkg::STAT_W-1:0]      status_r;
  logic [stkrm_pkg::OUT_CNT_W-1:0]   count_r;
  logic signed [stkrm_pkg::DATA_W-1:0] top_r;
  logic signed [stkrm_pkg::DATA_W-1:0] rdval_r;

  stkrm_ram #(
    .WIDTH (stkrm_pkg::DATA_W),
    .DEPTH (stkrm_pkg::STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

  stkrm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .in_position (in_position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      status_r <= res.status;
      count_r  <= stkrm_pkg::OUT_CNT_W'(res.count);
      top_r    <= res.top;
      rdval_r  <= res.rdval;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = count_r;
  assign out_top_value   = top_r;
  assign out_read_value  = rdval_r;

endmodule

@@ bench/stack_result_checker.sv @@
// ----------------------------------------------------------------------------
// Stack remove-by-value result checker
// Watches both channels of the stack. Each accepted request updates a
// private copy of the stack contents and queues the result that the block
// owes. Each accepted result is compared field by field with the oldest
// owed result. The mismatch count and the number of results still owed
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module stack_result_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [stkrm_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [stkrm_pkg::DATA_W-1:0]  in_value,
  input  logic [stkrm_pkg::POS_W-1:0]          in_position,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [stkrm_pkg::STAT_W-1:0]         out_status,
  input  logic [stkrm_pkg::OUT_CNT_W-1:0]      out_entry_count,
  input  logic signed [stkrm_pkg::DATA_W-1:0]  out_top_value,
  input  logic signed [stkrm_pkg::DATA_W-1:0]  out_read_value,
  output int unsigned                          mismatch_count,
  output int unsigned                          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import stkrm_pkg::*;

  typedef struct {
    stat_t                     status;
    logic [OUT_CNT_W-1:0]      entry_count;
    logic signed [DATA_W-1:0]  top_value;
    logic signed [DATA_W-1:0]  read_value;
  } stack_result_t;

  logic signed [DATA_W-1:0] entries [STACK_DEPTH];
  int                       held;
  stack_result_t            owed_q [$];

  function automatic stack_result_t apply_request(
    input logic [REQ_W-1:0]         req,
    input logic signed [DATA_W-1:0] value,
    input logic [POS_W-1:0]         pos
  );
    stack_result_t r;
    int            hit;
    r.status     = ST_OK;
    r.read_value = '0;
    case (req)
      REQ_PUSH: begin
        if (held >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entries[held] = value;
          held++;
        end
      end
      REQ_REMOVE: begin
        hit = -1;
        for (int i = held - 1; i >= 0 && hit < 0; i--) begin
          if (entries[i] == value) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int j = hit; j + 1 < held; j++) entries[j] = entries[j + 1];
          held--;
        end
      end
      REQ_READ: begin
        if (int'(pos) < held) r.read_value = entries[pos];
        else r.status = ST_RANGE;
      end
      default: begin
      end
    endcase
    r.entry_count = OUT_CNT_W'(held);
    r.top_value   = (held > 0) ? entries[held - 1] : '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    stack_result_t want;
    if (!rst_n) begin
      held           = 0;
      mismatch_count = 0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatch_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
            mismatch_count++;
          end
          if (out_top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, out_top_value);
            mismatch_count++;
          end
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        owed_q.push_back(apply_request(in_req_type, in_value, in_position));
      end
    end
    results_owed = owed_q.size();
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Stack remove-by-value testbench
// Drives push, remove and read requests into the stack: first a directed
// sequence that fills it past full, removes duplicates, the bottom entry and
// absent values, and reads in and out of range; then random requests in
// push-heavy and remove-heavy stretches over a small pool of values so that
// removes usually match. Both sides idle at random. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stkrm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int BLOCK_ITEMS    = 50;
  localparam int BLOCK_COUNT    = 30;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0] in_position;
  logic out_valid;
  logic out_stall;
  logic [STAT_W-1:0] out_status;
  logic [OUT_CNT_W-1:0] out_entry_count;
  logic signed [DATA_W-1:0] out_top_value;
  logic signed [DATA_W-1:0] out_read_value;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned idle_cycles;
  bit src_quiet;
  bit sink_quiet;
  int n_push, n_remove, n_read;
  int n_full, n_notfound, n_range;
  logic signed [DATA_W-1:0] value_pool [8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stack_remove_by_value_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry_count(out_entry_count),
    .out_top_value(out_top_value),
    .out_read_value(out_read_value)
  );

  stack_result_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry_count(out_entry_count),
    .out_top_value(out_top_value),
    .out_read_value(out_read_value),
    .mismatch_count(mismatch_count),
    .results_owed(results_owed)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : sink
    int wait_cycles;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      wait_cycles = sink_quiet ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (wait_cycles - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      case (out_status)
        ST_FULL:     n_full++;
        ST_NOTFOUND: n_notfound++;
        ST_RANGE:    n_range++;
        default: begin
        end
      endcase
    end
  end

  task automatic send_item(
    input req_t                     req,
    input logic signed [DATA_W-1:0] value,
    input logic [POS_W-1:0]         pos
  );
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= value;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    case (req)
      REQ_PUSH:   n_push++;
      REQ_REMOVE: n_remove++;
      default:    n_read++;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return value_pool[$urandom_range(0, 7)];
  endfunction

  task automatic send_random(input bit push_heavy);
    int   roll;
    req_t req;
    roll = $urandom_range(0, 9);
    if (roll < 2) req = REQ_READ;
    else if (roll < (push_heavy ? 8 : 4)) req = REQ_PUSH;
    else req = REQ_REMOVE;
    send_item(req, pick_value(), POS_W'($urandom_range(0, 15)));
  endtask

  initial begin : stimulus
    logic signed [DATA_W-1:0] fill_value;
    bit                       push_heavy;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_PUSH;
    in_value    = '0;
    in_position = '0;
    src_quiet   = 1'b0;
    sink_quiet  = 1'b0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(REQ_REMOVE, 32'sd5, '0);
    send_item(REQ_READ, '0, '0);
    for (int i = 0; i < STACK_DEPTH; i++) begin
      case (i)
        0:       fill_value = 32'sh8000_0000;
        1:       fill_value = 32'sh7fff_ffff;
        2:       fill_value = '0;
        3:       fill_value = -32'sd1;
        4, 10:   fill_value = 32'sd5;
        default: fill_value = $urandom;
      endcase
      send_item(REQ_PUSH, fill_value, POS_W'(i));
    end
    send_item(REQ_PUSH, 32'sd7, '0);
    send_item(REQ_READ, '0, 4'd0);
    send_item(REQ_READ, '0, 4'd15);
    send_item(REQ_REMOVE, 32'sd5, '0);
    send_item(REQ_REMOVE, 32'sh8000_0000, '0);
    send_item(REQ_REMOVE, 32'sd7, '0);
    send_item(REQ_READ, '0, 4'd15);
    send_item(REQ_REMOVE, 32'sh7fff_ffff, '0);
    send_item(REQ_READ, '0, 4'd0);

    for (int b = 0; b < BLOCK_COUNT; b++) begin
      push_heavy = $urandom_range(0, 1);
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BLOCK_ITEMS; k++) send_random(push_heavy);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d pushes, %0d removes and %0d reads to the stack.",
             n_push, n_remove, n_read);
    $display("Saw %0d pushes on a full stack, %0d removes without a match, %0d reads out of range.",
             n_full, n_notfound, n_range);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      if (results_owed != 0) $error("%0d results never arrived", results_owed);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/stkrm_pkg.sv
hw/rtl/stkrm_ram.sv
hw/rtl/stkrm_ctrl.sv
hw/rtl/stack_remove_by_value_top.sv
bench/stack_result_checker.sv
bench/tb.sv
